/* rtl/acb_pkg.sv */
// ----------------------------------------------------------------------------
// acb_pkg
// Shared types and constants of the address chunk bitmap.
// ----------------------------------------------------------------------------
package acb_pkg;

  localparam int unsigned DivSteps = 32;

  localparam logic [1:0] CFG_REGION_START = 2'd0;
  localparam logic [1:0] CFG_REGION_END   = 2'd1;
  localparam logic [1:0] CFG_CHUNK_SIZE   = 2'd2;
  localparam logic [1:0] CFG_MAP_BYTES    = 2'd3;

  typedef enum logic [2:0] {
    OP_CLR_ALL  = 3'd0,
    OP_CLR      = 3'd1,
    OP_SET      = 3'd2,
    OP_SET_RNG  = 3'd3,
    OP_TEST     = 3'd4,
    OP_TEST_ALL = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    DIV_ADDR,
    DIV_REND,
    DIV_REGION
  } div_sel_e;

  typedef enum logic [2:0] {
    SW_ALL,
    SW_USED,
    SW_SINGLE,
    SW_RANGE,
    SW_CHK
  } sweep_e;

  typedef enum logic [1:0] {
    WR_ZERO,
    WR_OR_MASK,
    WR_SINGLE
  } wr_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISPATCH,
    ST_CLR,
    ST_DIV_S,
    ST_SCHK,
    ST_SRD,
    ST_SMOD,
    ST_DIV_R1,
    ST_DIV_R2,
    ST_RCHK,
    ST_RRD,
    ST_RWR,
    ST_DIV_C,
    ST_CRD,
    ST_CEV
  } state_e;

  typedef struct packed {
    logic     latch;
    logic     div_start;
    div_sel_e div_sel;
    logic     save_first;
    logic     save_last;
    logic     sw_load;
    sweep_e   sw_kind;
    logic     mem_rd;
    logic     mem_wr;
    wr_e      wr_kind;
    logic     ptr_inc;
    logic     ans_init;
    logic     ans_check;
    logic     ans_bit;
    logic     finish;
    logic     fin_acc;
    logic     fin_ans;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic map_ok;
    logic in_region;
    logic rng_ok;
    logic slot_ok;
    logic last_ok;
    logic div_busy;
    logic sw_empty;
    logic sw_last;
    logic out_busy;
  } sts_t;

endpackage

/* rtl/acb_dp.sv */
// ----------------------------------------------------------------------------
// acb_dp
// Datapath: configuration, item registers, serial divider, bitmap memory,
// byte sweep pointer and result register.
// ----------------------------------------------------------------------------
module acb_dp #(
  parameter int unsigned MapBytes = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [31:0]   cfg_data_i,
  input  logic [2:0]    opcode_i,
  input  logic [31:0]   address_i,
  input  logic [31:0]   range_end_i,
  input  logic          out_ready_i,
  input  acb_pkg::cmd_t cmd_i,
  output acb_pkg::sts_t sts_o,
  output logic          out_valid_o,
  output logic          answer_o,
  output logic          accepted_o
);
  import acb_pkg::*;

  localparam int unsigned AW = (MapBytes > 1) ? $clog2(MapBytes) : 1;
  localparam int unsigned PW = $clog2(MapBytes + 1);
  localparam int unsigned XW = PW + 3;

  logic [31:0] rs_q, re_q, cs_q;
  logic [6:0]  mb_q;
  op_e         op_q;
  logic [31:0] addr_q, rend_q;

  logic [31:0] quo_q;
  logic [32:0] rem_q;
  logic [5:0]  cnt_q;
  logic [31:0] first_q;
  logic [32:0] last_q;

  logic [PW-1:0] ptr_q, end_q;
  logic [XW-1:0] lo_q, hi_q;
  logic [2:0]    bit_q;

  logic [7:0] mem_q [MapBytes];
  logic [7:0] rdata_q;
  logic       ans_q;
  logic       out_valid_q, out_ans_q, out_acc_q;

  logic [PW-1:0] used;
  logic [31:0]   cap32;
  logic [31:0]   dividend;
  logic [32:0]   shl;
  logic          ge;
  logic [31:0]   cnt32;
  logic [7:0]    mask;
  logic [7:0]    bitm;
  logic [7:0]    wdata;

  always_comb begin
    used = (32'(mb_q) > 32'(MapBytes)) ? PW'(MapBytes) : PW'(mb_q);
    cap32 = 32'(used) << 3;
    case (cmd_i.div_sel)
      DIV_ADDR: dividend = addr_q - rs_q;
      DIV_REND: dividend = rend_q - rs_q;
      default:  dividend = re_q - rs_q;
    endcase
    shl = {rem_q[31:0], quo_q[31]};
    ge = shl >= {1'b0, cs_q};
    cnt32 = (quo_q < cap32) ? quo_q : cap32;
    for (int j = 0; j < 8; j++) begin
      mask[j] = ({ptr_q, 3'(j)} >= lo_q) && ({ptr_q, 3'(j)} < hi_q);
    end
    bitm = 8'd1 << bit_q;
    case (cmd_i.wr_kind)
      WR_OR_MASK: wdata = rdata_q | mask;
      WR_SINGLE:  wdata = (op_q == OP_SET) ? (rdata_q | bitm) : (rdata_q & ~bitm);
      default:    wdata = 8'h00;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_q <= '0;
      re_q <= '0;
      cs_q <= '0;
      mb_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_REGION_START: rs_q <= cfg_data_i;
        CFG_REGION_END:   re_q <= cfg_data_i;
        CFG_CHUNK_SIZE:   cs_q <= cfg_data_i;
        CFG_MAP_BYTES:    mb_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q   <= op_e'(opcode_i);
      addr_q <= address_i;
      rend_q <= range_end_i;
    end
    if (cmd_i.div_start) begin
      quo_q <= dividend;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[30:0], ge};
      rem_q <= ge ? (shl - {1'b0, cs_q}) : shl;
    end
    if (cmd_i.save_first) first_q <= quo_q;
    if (cmd_i.save_last) last_q <= {1'b0, quo_q} + 33'(rem_q != '0);
    if (cmd_i.sw_load) begin
      case (cmd_i.sw_kind)
        SW_SINGLE: bit_q <= first_q[2:0];
        SW_RANGE: begin
          lo_q <= XW'(first_q);
          hi_q <= XW'(last_q);
        end
        SW_CHK: begin
          lo_q <= '0;
          hi_q <= XW'(cnt32);
        end
        default: ;
      endcase
    end
    if (cmd_i.mem_wr) mem_q[ptr_q[AW-1:0]] <= wdata;
    if (cmd_i.mem_rd) rdata_q <= mem_q[ptr_q[AW-1:0]];
    if (cmd_i.ans_init) begin
      ans_q <= 1'b1;
    end else if (cmd_i.ans_check) begin
      if ((rdata_q & mask) != 8'h00) ans_q <= 1'b0;
    end else if (cmd_i.ans_bit) begin
      ans_q <= rdata_q[bit_q];
    end
    if (cmd_i.finish) begin
      out_ans_q <= cmd_i.fin_ans & ans_q;
      out_acc_q <= cmd_i.fin_acc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ptr_q       <= '0;
      end_q       <= PW'(MapBytes);
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.div_start) begin
        cnt_q <= 6'(DivSteps);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 6'd1;
      end
      if (cmd_i.sw_load) begin
        case (cmd_i.sw_kind)
          SW_ALL: begin
            ptr_q <= '0;
            end_q <= PW'(MapBytes);
          end
          SW_USED: begin
            ptr_q <= '0;
            end_q <= used;
          end
          SW_SINGLE: begin
            ptr_q <= PW'(first_q >> 3);
            end_q <= PW'(first_q >> 3) + PW'(1);
          end
          SW_RANGE: begin
            ptr_q <= PW'(first_q >> 3);
            end_q <= PW'(((last_q - 33'd1) >> 3) + 33'd1);
          end
          default: begin
            ptr_q <= '0;
            end_q <= PW'((cnt32 + 32'd7) >> 3);
          end
        endcase
      end else if (cmd_i.ptr_inc) begin
        ptr_q <= ptr_q + PW'(1);
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.op        = op_q;
    sts_o.map_ok    = (cs_q != '0) && (mb_q != '0);
    sts_o.in_region = (addr_q >= rs_q) && (addr_q < re_q);
    sts_o.rng_ok    = (addr_q >= rs_q) && (rend_q < re_q) && (addr_q < rend_q);
    sts_o.slot_ok   = first_q < cap32;
    sts_o.last_ok   = last_q <= {1'b0, cap32};
    sts_o.div_busy  = cnt_q != '0;
    sts_o.sw_empty  = ptr_q == end_q;
    sts_o.sw_last   = (ptr_q + PW'(1)) == end_q;
    sts_o.out_busy  = out_valid_q && !out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign answer_o    = out_ans_q;
  assign accepted_o  = out_acc_q;

  a_wr_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mem_wr |-> (ptr_q < PW'(MapBytes)))
    else $error("bitmap write beyond storage");

  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> !(out_valid_q && !out_ready_i))
    else $error("result overwrites a pending item");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> (cnt_q == '0))
    else $error("divider restarted while busy");

endmodule

/* rtl/acb_ctrl.sv */
// ----------------------------------------------------------------------------
// acb_ctrl
// Controller: sequences each item through divider, memory and sweep steps.
// ----------------------------------------------------------------------------
module acb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  acb_pkg::sts_t sts_i,
  output acb_pkg::cmd_t cmd_o
);
  import acb_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  logic fin_go;
  logic fin_acc, fin_use;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    fin_go  = 1'b0;
    fin_acc = 1'b0;
    fin_use = 1'b0;
    in_ready_o = 1'b0;

    case (state_q)
      ST_INIT: begin
        cmd_o.mem_wr  = 1'b1;
        cmd_o.wr_kind = WR_ZERO;
        cmd_o.ptr_inc = 1'b1;
        if (sts_i.sw_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (!sts_i.map_ok) begin
          fin_go = 1'b1;
        end else begin
          case (sts_i.op)
            OP_CLR_ALL: begin
              cmd_o.sw_load = 1'b1;
              cmd_o.sw_kind = SW_USED;
              state_d = ST_CLR;
            end
            OP_CLR, OP_SET, OP_TEST: begin
              if (sts_i.in_region) begin
                cmd_o.div_start = 1'b1;
                cmd_o.div_sel   = DIV_ADDR;
                state_d = ST_DIV_S;
              end else begin
                fin_go = 1'b1;
              end
            end
            OP_SET_RNG: begin
              if (sts_i.rng_ok) begin
                cmd_o.div_start = 1'b1;
                cmd_o.div_sel   = DIV_ADDR;
                state_d = ST_DIV_R1;
              end else begin
                fin_go = 1'b1;
              end
            end
            OP_TEST_ALL: begin
              cmd_o.div_start = 1'b1;
              cmd_o.div_sel   = DIV_REGION;
              state_d = ST_DIV_C;
            end
            default: fin_go = 1'b1;
          endcase
        end
      end
      ST_CLR: begin
        cmd_o.mem_wr  = 1'b1;
        cmd_o.wr_kind = WR_ZERO;
        cmd_o.ptr_inc = 1'b1;
        if (sts_i.sw_last) begin
          fin_go  = 1'b1;
          fin_acc = 1'b1;
        end
      end
      ST_DIV_S: begin
        if (!sts_i.div_busy) begin
          cmd_o.save_first = 1'b1;
          state_d = ST_SCHK;
        end
      end
      ST_SCHK: begin
        if (!sts_i.slot_ok) begin
          fin_go = 1'b1;
        end else begin
          cmd_o.sw_load = 1'b1;
          cmd_o.sw_kind = SW_SINGLE;
          state_d = ST_SRD;
        end
      end
      ST_SRD: begin
        cmd_o.mem_rd = 1'b1;
        state_d = ST_SMOD;
      end
      ST_SMOD: begin
        fin_go  = 1'b1;
        fin_acc = 1'b1;
        if (sts_i.op == OP_TEST) begin
          cmd_o.ans_bit = 1'b1;
          fin_use = 1'b1;
        end else begin
          cmd_o.mem_wr  = 1'b1;
          cmd_o.wr_kind = WR_SINGLE;
        end
      end
      ST_DIV_R1: begin
        if (!sts_i.div_busy) begin
          cmd_o.save_first = 1'b1;
          cmd_o.div_start  = 1'b1;
          cmd_o.div_sel    = DIV_REND;
          state_d = ST_DIV_R2;
        end
      end
      ST_DIV_R2: begin
        if (!sts_i.div_busy) begin
          cmd_o.save_last = 1'b1;
          state_d = ST_RCHK;
        end
      end
      ST_RCHK: begin
        if (!sts_i.last_ok) begin
          fin_go = 1'b1;
        end else begin
          cmd_o.sw_load = 1'b1;
          cmd_o.sw_kind = SW_RANGE;
          state_d = ST_RRD;
        end
      end
      ST_RRD: begin
        cmd_o.mem_rd = 1'b1;
        state_d = ST_RWR;
      end
      ST_RWR: begin
        cmd_o.mem_wr  = 1'b1;
        cmd_o.wr_kind = WR_OR_MASK;
        cmd_o.ptr_inc = 1'b1;
        if (sts_i.sw_last) begin
          fin_go  = 1'b1;
          fin_acc = 1'b1;
        end else begin
          state_d = ST_RRD;
        end
      end
      ST_DIV_C: begin
        if (!sts_i.div_busy) begin
          cmd_o.sw_load  = 1'b1;
          cmd_o.sw_kind  = SW_CHK;
          cmd_o.ans_init = 1'b1;
          state_d = ST_CRD;
        end
      end
      ST_CRD: begin
        if (sts_i.sw_empty) begin
          fin_go  = 1'b1;
          fin_acc = 1'b1;
          fin_use = 1'b1;
        end else begin
          cmd_o.mem_rd = 1'b1;
          state_d = ST_CEV;
        end
      end
      ST_CEV: begin
        cmd_o.ans_check = 1'b1;
        cmd_o.ptr_inc   = 1'b1;
        if (sts_i.sw_last) begin
          fin_go  = 1'b1;
          fin_acc = 1'b1;
          fin_use = 1'b1;
        end else begin
          state_d = ST_CRD;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // hand the result to the output stage
    if (fin_go) begin
      cmd_o.finish  = 1'b1;
      cmd_o.fin_acc = fin_acc;
      cmd_o.fin_ans = fin_use;
      state_d       = ST_IDLE;
    end
  end

endmodule

/* rtl/acb_fin.sv */
// ----------------------------------------------------------------------------
// acb_fin
// Result hand-off: holds a finished item until the output register frees.
// ----------------------------------------------------------------------------
module acb_fin (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          done_i,
  input  logic          done_acc_i,
  input  logic          done_ans_i,
  input  logic          out_busy_i,
  output logic          pend_o,
  output logic          finish_o,
  output logic          fin_acc_o,
  output logic          fin_ans_o
);
  logic pend_q, pend_d;
  logic acc_q, acc_d, ans_q, ans_d;

  always_comb begin
    pend_d = pend_q;
    acc_d  = acc_q;
    ans_d  = ans_q;
    if (done_i) begin
      pend_d = 1'b1;
      acc_d  = done_acc_i;
      ans_d  = done_ans_i;
    end else if (pend_q && !out_busy_i) begin
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      acc_q  <= 1'b0;
      ans_q  <= 1'b0;
    end else begin
      pend_q <= pend_d;
      acc_q  <= acc_d;
      ans_q  <= ans_d;
    end
  end

  assign pend_o    = pend_q;
  assign finish_o  = pend_q && !out_busy_i;
  assign fin_acc_o = acc_q;
  assign fin_ans_o = ans_q;

endmodule

/* rtl/address_chunk_bitmap_core.sv */
// ----------------------------------------------------------------------------
// address_chunk_bitmap_core
// One bit per chunk-sized slot of an address region, with set, clear, range
// set and test operations.
// ----------------------------------------------------------------------------
// One item is worked at a time, one result per item. Single clear, set and
// test first map the address to its slot with the 32-step serial divider.
// Range set does two divisions, then a read and a write of the memory per
// bitmap byte touched. Clear all writes zero to each byte in use; the
// all-clear test does one division, then a read and a check per byte
// examined. After reset the bitmap memory is swept to zero over all MapBytes
// bytes, one byte a cycle, before the first item is taken; configuration
// writes are taken at any time.
module address_chunk_bitmap_core #(
  parameter int unsigned MapBytes = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [31:0] address_i,
  input  logic [31:0] range_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        answer_o,
  output logic        accepted_o
);
  import acb_pkg::*;

  cmd_t cmd_c, cmd;
  sts_t sts;
  logic ctrl_ready;
  logic pend, finish, fin_acc, fin_ans;

  acb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i && !pend),
    .in_ready_o (ctrl_ready),
    .sts_i      (sts),
    .cmd_o      (cmd_c)
  );

  acb_fin u_fin (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .done_i     (cmd_c.finish),
    .done_acc_i (cmd_c.fin_acc),
    .done_ans_i (cmd_c.fin_ans),
    .out_busy_i (sts.out_busy),
    .pend_o     (pend),
    .finish_o   (finish),
    .fin_acc_o  (fin_acc),
    .fin_ans_o  (fin_ans)
  );

  always_comb begin
    cmd = cmd_c;
    cmd.finish  = finish;
    cmd.fin_acc = fin_acc;
    cmd.fin_ans = fin_ans;
  end

  assign in_ready_o = ctrl_ready && !pend;

  acb_dp #(
    .MapBytes (MapBytes)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .opcode_i    (opcode_i),
    .address_i   (address_i),
    .range_end_i (range_end_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .answer_o    (answer_o),
    .accepted_o  (accepted_o)
  );

endmodule
